FILE: sv/ack_retry_tracker_with_rtt_stats_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ack retry tracker
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ACK_RETRY_TRACKER_WITH_RTT_STATS_MACROS_SVH
`define ACK_RETRY_TRACKER_WITH_RTT_STATS_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ART_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ART_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: sv/art_pkg.sv
// ----------------------------------------------------------------------------
// Ack retry tracker package
// Sizes, operation and result codes, sequencer states.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int TableDepth = 16;
  localparam int SlotW      = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam logic [15:0] TimeoutReset = 16'd2000;
  localparam logic [3:0]  LimitReset   = 4'd3;

  localparam logic [2:0] OP_SEND  = 3'd0;
  localparam logic [2:0] OP_ACK   = 3'd1;
  localparam logic [2:0] OP_PONG  = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_START = 3'd4;

  localparam logic [2:0] K_REG     = 3'd0;
  localparam logic [2:0] K_FULL    = 3'd1;
  localparam logic [2:0] K_ACKED   = 3'd2;
  localparam logic [2:0] K_UNMATCH = 3'd3;
  localparam logic [2:0] K_RESEND  = 3'd4;
  localparam logic [2:0] K_FAIL    = 3'd5;
  localparam logic [2:0] K_STARTED = 3'd6;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_SEND, S_MATCH, S_MEAS, S_SCAN, S_RES, S_FAILR, S_START
  } state_t;

endpackage

FILE: sv/ack_retry_tracker_with_rtt_stats.sv
// ----------------------------------------------------------------------------
// Ack retry tracker with RTT statistics
// Send, ack, pong: the table is scanned one slot a cycle, then the result is
// loaded. Series start: a result from S_START, none for a zero series count.
// Tick: a scan, then a resend pass and a failure pass, held by any output
// stall. Input is stalled until idle. Reset (rst_n low, synchronous) empties
// the table, clears clock and statistics and restores the register defaults.
// ----------------------------------------------------------------------------
module ack_retry_tracker_with_rtt_stats import art_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_msg_id,
  input  logic        in_is_ping,
  input  logic [15:0] in_series_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_out_id,
  output logic [3:0]  out_retry_number,
  output logic [15:0] out_rtt_ms,
  output logic        out_rtt_valid,
  output logic [15:0] out_jitter_ms,
  output logic        out_jitter_valid,
  output logic [15:0] out_received_count,
  output logic [15:0] out_lost_count,
  output logic [31:0] out_rtt_total,
  output logic [31:0] out_jitter_total,
  output logic        out_last
);

  state_t state_r, state_nxt;
  logic [15:0] timeout_r;
  logic [3:0]  limit_r;
  logic [31:0] clock_r;
  logic [TableDepth-1:0] valid_r, ping_r, fail_r, rs_r;
  logic [31:0] id_mem [TableDepth];
  logic [31:0] sent_mem [TableDepth];
  logic [3:0]  retry_mem [TableDepth];
  logic [15:0] prev_r, answered_r, failed_r;
  logic        have_prev_r;
  logic [31:0] rtt_acc_r, jit_acc_r;

  logic [2:0]  op_r;
  logic [31:0] id_r;
  logic        is_ping_r;
  logic [CntW-1:0] idx_r;
  logic        hit_r, free_ok_r;
  logic [SlotW-1:0] hit_slot_r, free_slot_r;
  logic [CntW-1:0] nres_r;

  logic [2:0]  o_kind_r;
  logic [31:0] o_id_r;
  logic [3:0]  o_retry_r;
  logic [15:0] o_rtt_r, o_jit_r;
  logic        o_rttv_r, o_jitv_r, o_last_r, o_valid_r;

  logic [SlotW-1:0] sl, ws;
  logic [31:0] el;
  logic        expired, out_free, at_end, o_load;
  logic [15:0] rtt, jit;

  function automatic logic [31:0] sat32(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    sat32 = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  assign sl  = (state_r == S_MEAS) ? hit_slot_r : idx_r[SlotW-1:0];
  assign ws  = hit_r ? hit_slot_r : free_slot_r;
  assign el  = clock_r - sent_mem[sl];
  assign expired = valid_r[sl] && (el >= {16'd0, timeout_r});
  assign rtt = (el > 32'h0000_FFFF) ? 16'hFFFF : el[15:0];
  assign jit = (rtt >= prev_r) ? rtt - prev_r : prev_r - rtt;
  assign out_free = !o_valid_r || !out_stall;
  assign at_end   = (idx_r == CntW'(TableDepth));

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    o_load = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        case (in_op)
          OP_SEND:          state_nxt = S_FIND;
          OP_ACK, OP_PONG:  state_nxt = S_MATCH;
          OP_TICK:          state_nxt = S_SCAN;
          OP_START:         state_nxt = (in_series_count != 16'd0) ? S_START : S_IDLE;
          default:          state_nxt = S_IDLE;
        endcase
      end
      S_FIND:  if (idx_r == CntW'(TableDepth - 1)) state_nxt = S_SEND;
      S_MATCH: if (idx_r == CntW'(TableDepth - 1)) state_nxt = S_MEAS;
      S_SCAN:  if (idx_r == CntW'(TableDepth - 1)) state_nxt = S_RES;
      S_SEND, S_MEAS, S_START: if (out_free) begin
        o_load = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RES: if (out_free) begin
        if (at_end) state_nxt = S_FAILR;
        else o_load = rs_r[sl];
      end
      S_FAILR: if (out_free) begin
        if (at_end) state_nxt = S_IDLE;
        else o_load = fail_r[sl];
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutReset;
      limit_r <= LimitReset;
      clock_r <= '0;
      valid_r <= '0;
      ping_r <= '0;
      prev_r <= '0;
      have_prev_r <= 1'b0;
      answered_r <= '0;
      failed_r <= '0;
      rtt_acc_r <= '0;
      jit_acc_r <= '0;
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_load || (o_valid_r && out_stall);
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) timeout_r <= cfg_wdata;
        else limit_r <= cfg_wdata[3:0];
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_op;
          id_r <= in_msg_id;
          is_ping_r <= in_is_ping;
          idx_r <= '0;
          hit_r <= 1'b0;
          free_ok_r <= 1'b0;
          nres_r <= '0;
          fail_r <= '0;
          rs_r <= '0;
          if (in_op == OP_TICK) clock_r <= clock_r + 32'd1;
        end
        S_FIND, S_MATCH: begin
          if (!hit_r && valid_r[sl] && id_mem[sl] == id_r) begin
            hit_r <= 1'b1;
            hit_slot_r <= sl;
          end
          if (!free_ok_r && !valid_r[sl]) begin
            free_ok_r <= 1'b1;
            free_slot_r <= sl;
          end
          idx_r <= idx_r + CntW'(1);
        end
        S_SEND: if (out_free) begin
          o_kind_r <= (hit_r || free_ok_r) ? K_REG : K_FULL;
          if (hit_r || free_ok_r) begin
            valid_r[ws] <= 1'b1;
            ping_r[ws] <= is_ping_r;
            id_mem[ws] <= id_r;
            sent_mem[ws] <= clock_r;
            retry_mem[ws] <= '0;
          end
          o_id_r <= id_r; o_retry_r <= '0; o_last_r <= 1'b1;
          o_rtt_r <= '0; o_rttv_r <= 1'b0; o_jit_r <= '0; o_jitv_r <= 1'b0;
        end
        S_MEAS: if (out_free) begin
          o_id_r <= id_r; o_retry_r <= '0; o_last_r <= 1'b1;
          o_rtt_r <= '0; o_rttv_r <= 1'b0; o_jit_r <= '0; o_jitv_r <= 1'b0;
          o_kind_r <= hit_r ? K_ACKED : K_UNMATCH;
          if (hit_r) valid_r[hit_slot_r] <= 1'b0;
          if (hit_r && op_r == OP_PONG && ping_r[hit_slot_r]) begin
            o_rtt_r <= rtt;
            o_rttv_r <= 1'b1;
            if (answered_r != 16'hFFFF) answered_r <= answered_r + 16'd1;
            rtt_acc_r <= sat32(rtt_acc_r, rtt);
            if (have_prev_r) begin
              o_jit_r <= jit;
              o_jitv_r <= 1'b1;
              jit_acc_r <= sat32(jit_acc_r, jit);
            end
            prev_r <= rtt;
            have_prev_r <= 1'b1;
          end
        end
        S_START: if (out_free) begin
          answered_r <= '0; failed_r <= '0; prev_r <= '0; have_prev_r <= 1'b0;
          rtt_acc_r <= '0; jit_acc_r <= '0; ping_r <= '0;
          o_kind_r <= K_STARTED; o_id_r <= '0; o_retry_r <= '0; o_last_r <= 1'b1;
          o_rtt_r <= '0; o_rttv_r <= 1'b0; o_jit_r <= '0; o_jitv_r <= 1'b0;
        end
        S_SCAN: begin
          if (expired && nres_r != CntW'(TableDepth)) begin
            nres_r <= nres_r + CntW'(1);
            if (retry_mem[sl] >= limit_r) fail_r[sl] <= 1'b1;
            else begin
              retry_mem[sl] <= retry_mem[sl] + 4'd1;
              sent_mem[sl] <= clock_r;
              rs_r[sl] <= 1'b1;
            end
          end
          idx_r <= (idx_r == CntW'(TableDepth - 1)) ? '0 : idx_r + CntW'(1);
        end
        S_RES: if (out_free) begin
          if (at_end) begin
            idx_r <= '0;
          end else begin
            idx_r <= idx_r + CntW'(1);
            if (rs_r[sl]) begin
              o_kind_r <= K_RESEND; o_id_r <= id_mem[sl]; o_retry_r <= retry_mem[sl];
              o_rtt_r <= '0; o_rttv_r <= 1'b0; o_jit_r <= '0; o_jitv_r <= 1'b0;
              o_last_r <= (nres_r == CntW'(1));
              nres_r <= nres_r - CntW'(1);
            end
          end
        end
        S_FAILR: if (out_free && !at_end) begin
          idx_r <= idx_r + CntW'(1);
          if (fail_r[sl]) begin
            valid_r[sl] <= 1'b0;
            if (ping_r[sl] && failed_r != 16'hFFFF) failed_r <= failed_r + 16'd1;
            o_kind_r <= K_FAIL; o_id_r <= id_mem[sl]; o_retry_r <= limit_r;
            o_rtt_r <= '0; o_rttv_r <= 1'b0; o_jit_r <= '0; o_jitv_r <= 1'b0;
            o_last_r <= (nres_r == CntW'(1));
            nres_r <= nres_r - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = o_valid_r;
  assign out_kind           = o_kind_r;
  assign out_out_id         = o_id_r;
  assign out_retry_number   = o_retry_r;
  assign out_rtt_ms         = o_rtt_r;
  assign out_rtt_valid      = o_rttv_r;
  assign out_jitter_ms      = o_jit_r;
  assign out_jitter_valid   = o_jitv_r;
  assign out_received_count = answered_r;
  assign out_lost_count     = failed_r;
  assign out_rtt_total      = rtt_acc_r;
  assign out_jitter_total   = jit_acc_r;
  assign out_last           = o_last_r;

endmodule

FILE: sv/art_checker.sv
// ----------------------------------------------------------------------------
// Ack retry tracker port checker
// Port-level properties of the item channels.
// ----------------------------------------------------------------------------
`include "ack_retry_tracker_with_rtt_stats_macros.svh"
module art_checker import art_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic        out_rtt_valid,
  input logic        out_jitter_valid,
  input logic [15:0] out_jitter_ms
);
  `ART_ASSERT_IMP(a_jit_needs_rtt, clk, rst_n, out_valid && out_jitter_valid, out_rtt_valid, "jitter without rtt")
  `ART_ASSERT_IMP(a_rtt_acked, clk, rst_n, out_valid && out_rtt_valid, out_kind == K_ACKED, "rtt on non-ack")
  `ART_ASSERT_IMP(a_jit_zero, clk, rst_n, out_valid && !out_jitter_valid, out_jitter_ms == 16'd0, "stray jitter")
  `ART_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_kind), "stalled item dropped")
  `ART_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid, "stalled input withdrawn")
endmodule

bind ack_retry_tracker_with_rtt_stats art_checker u_art_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
  .out_rtt_valid(out_rtt_valid), .out_jitter_valid(out_jitter_valid),
  .out_jitter_ms(out_jitter_ms)
);
